FILE: src/dra_pkg.sv
`default_nettype none
package dra_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_BATCH   = 16;

    // Field widths of the item and result formats
    localparam int FUNC_W    = 2;
    localparam int COUNT_W   = 5;
    localparam int SLOT_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 64;
    localparam int STRIDE_W  = 13;
    localparam int REL_W     = 11;
    localparam int CAP_W     = 11;
    localparam int WAIT_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int OFF_W     = SLOT_W + STRIDE_W;

    // Stack and pending list geometry
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int DEPTH_W = IDX_W + 1;

    // Queues
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd5;

    // Reset values of the registers
    localparam int CAP_RESET = (1024 > MAX_ENTRIES) ? MAX_ENTRIES : 1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;
    localparam logic [WAIT_W-1:0]   DELAY_RESET  = 8'd10;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // Status codes of a result
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PFULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot_index;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted_index;
        logic [ADDR_W-1:0]   cpu_address;
        logic [ADDR_W-1:0]   gpu_address;
        logic [STRIDE_W-1:0] slot_stride;
        logic [REL_W-1:0]    released_count;
        logic                last;
    } t_result;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

    typedef struct packed {
        logic                shader_visible;
        logic [ADDR_W-1:0]   cpu_base;
        logic [ADDR_W-1:0]   gpu_base;
        logic [STRIDE_W-1:0] stride;
        logic [WAIT_W-1:0]   release_delay;
    } t_cfg;

    typedef struct packed {
        logic             req;
        logic [CAP_W-1:0] capacity;
    } t_rebuild;

    typedef struct packed {
        logic [DEPTH_W-1:0] free_depth;
        logic [DEPTH_W-1:0] pending_depth;
    } t_back_stat;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [WAIT_W-1:0] wait_cnt;
    } t_pend;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ALLOC_RD,
        B_ALLOC_MUL,
        B_ALLOC_ADD,
        B_NOFREE,
        B_FREE,
        B_TICK_RUN,
        B_TICK_DONE
    } t_bstate;

endpackage
`default_nettype wire

FILE: src/dra_ram.sv
`default_nettype none
module dra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/dra_front.sv
`default_nettype none
module dra_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire dra_pkg::t_item i_item,
    output logic               full,
    output logic               o_cmd_valid,
    output dra_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_ready
);

    dra_pkg::t_cmd                      r_q [dra_pkg::CMDQ_DEPTH];
    logic [dra_pkg::CMDQ_PTR_W-1:0]     r_wp;
    logic [dra_pkg::CMDQ_PTR_W-1:0]     r_rp;
    logic [dra_pkg::CMDQ_CNT_W-1:0]     r_cnt;

    logic          w_keep;
    dra_pkg::t_cmd w_cmd;
    logic          w_enq;
    logic          w_deq;

    // Classify: drop unknown codes and empty allocations, clip the batch size
    always_comb begin
        w_keep       = 1'b0;
        w_cmd.op     = dra_pkg::OP_ALLOC;
        w_cmd.count  = i_item.count;
        w_cmd.slot   = i_item.slot_index;
        unique case (i_item.func)
            dra_pkg::FUNC_ALLOC: begin
                w_keep = (i_item.count != '0);
                if (int'(i_item.count) > dra_pkg::MAX_BATCH) begin
                    w_cmd.count = dra_pkg::COUNT_W'(dra_pkg::MAX_BATCH);
                end
            end
            dra_pkg::FUNC_FREE: begin
                w_keep   = 1'b1;
                w_cmd.op = dra_pkg::OP_FREE;
            end
            dra_pkg::FUNC_TICK: begin
                w_keep   = 1'b1;
                w_cmd.op = dra_pkg::OP_TICK;
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign full        = (r_cnt == dra_pkg::CMDQ_CNT_W'(dra_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_enq       = push && !full && w_keep;
    assign w_deq       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + dra_pkg::CMDQ_CNT_W'(w_enq) - dra_pkg::CMDQ_CNT_W'(w_deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: src/dra_back.sv
`default_nettype none
module dra_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dra_pkg::t_cfg     i_cfg,
    input  wire dra_pkg::t_rebuild i_rebuild,
    input  wire logic              i_cmd_valid,
    input  wire dra_pkg::t_cmd     i_cmd,
    output logic                   o_cmd_ready,
    output logic                   o_res_push,
    output dra_pkg::t_result       o_res,
    input  wire logic              i_res_full,
    output dra_pkg::t_back_stat    o_stat
);

    localparam int IW = dra_pkg::IDX_W;
    localparam int DW = dra_pkg::DEPTH_W;
    localparam logic [DW-1:0] FULL_DEPTH = DW'(dra_pkg::MAX_ENTRIES);

    dra_pkg::t_bstate r_state, n_state;
    logic [DW-1:0] r_fd, n_fd;
    logic [DW-1:0] r_pd, n_pd;
    logic [DW-1:0] r_low, n_low;
    logic [DW-1:0] r_rd, n_rd;
    logic [DW-1:0] r_wr, n_wr;
    logic          r_tv, n_tv;
    logic          r_from_mark, n_from_mark;
    logic [dra_pkg::REL_W-1:0]   r_rel, n_rel;
    logic [dra_pkg::COUNT_W-1:0] r_left, n_left;
    logic [IW-1:0]               r_pos, n_pos;
    logic [dra_pkg::SLOT_W-1:0]  r_idx, n_idx;
    logic [dra_pkg::OFF_W-1:0]   r_off, n_off;
    logic [dra_pkg::SLOT_W-1:0]  r_slot, n_slot;

    logic [DW-1:0]              w_fd_dec;
    logic [IW-1:0]              w_top;
    logic                       w_stk_we;
    logic [IW-1:0]              w_stk_waddr;
    logic [dra_pkg::SLOT_W-1:0] w_stk_wdata;
    logic [dra_pkg::SLOT_W-1:0] w_stk_rdata;
    logic                       w_pnd_we;
    logic [IW-1:0]              w_pnd_waddr;
    dra_pkg::t_pend             w_pnd_wdata;
    logic [$bits(dra_pkg::t_pend)-1:0] w_pnd_rbits;
    dra_pkg::t_pend             w_pnd_rdata;
    logic [dra_pkg::SLOT_W-1:0] w_pick;
    logic [dra_pkg::WAIT_W-1:0] w_wait_dec;

    assign w_fd_dec    = r_fd - DW'(1);
    assign w_top       = w_fd_dec[IW-1:0];
    assign w_pnd_rdata = dra_pkg::t_pend'(w_pnd_rbits);

    dra_ram #(
        .WIDTH (dra_pkg::SLOT_W),
        .DEPTH (dra_pkg::MAX_ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_top),
        .o_rdata (w_stk_rdata)
    );

    dra_ram #(
        .WIDTH ($bits(dra_pkg::t_pend)),
        .DEPTH (dra_pkg::MAX_ENTRIES)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (w_pnd_we),
        .i_waddr (w_pnd_waddr),
        .i_wdata (w_pnd_wdata),
        .i_raddr (r_rd[IW-1:0]),
        .o_rdata (w_pnd_rbits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dra_pkg::B_IDLE;
            r_fd        <= DW'(dra_pkg::CAP_RESET);
            r_low       <= DW'(dra_pkg::CAP_RESET);
            r_pd        <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_tv        <= 1'b0;
            r_from_mark <= 1'b0;
            r_rel       <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_fd        <= n_fd;
            r_low       <= n_low;
            r_pd        <= n_pd;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_tv        <= n_tv;
            r_from_mark <= n_from_mark;
            r_rel       <= n_rel;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_off  <= n_off;
        r_slot <= n_slot;
    end

    always_comb begin
        n_state     = r_state;
        n_fd        = r_fd;
        n_low       = r_low;
        n_pd        = r_pd;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_tv        = r_tv;
        n_from_mark = r_from_mark;
        n_rel       = r_rel;
        n_left      = r_left;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_off       = r_off;
        n_slot      = r_slot;

        o_cmd_ready = 1'b0;
        o_res_push  = 1'b0;
        o_res                = '0;
        o_res.status         = dra_pkg::STATUS_OK;
        o_res.slot_stride    = i_cfg.stride;
        o_res.last           = 1'b1;

        w_stk_we    = 1'b0;
        w_stk_waddr = r_fd[IW-1:0];
        w_stk_wdata = w_pnd_rdata.slot;
        w_pnd_we    = 1'b0;
        w_pnd_waddr = r_wr[IW-1:0];
        w_pnd_wdata = w_pnd_rdata;
        w_pick      = r_from_mark ? dra_pkg::SLOT_W'(r_pos) : w_stk_rdata;
        w_wait_dec  = (w_pnd_rdata.wait_cnt == '0) ? '0 : w_pnd_rdata.wait_cnt - 1'b1;

        unique case (r_state)
            dra_pkg::B_IDLE: begin
                o_cmd_ready = 1'b1;
                n_slot      = i_cmd.slot;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        dra_pkg::OP_ALLOC: begin
                            n_left  = i_cmd.count;
                            n_state = dra_pkg::B_ALLOC_RD;
                        end
                        dra_pkg::OP_FREE: begin
                            n_state = dra_pkg::B_FREE;
                        end
                        dra_pkg::OP_TICK: begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_tv    = 1'b0;
                            n_rel   = '0;
                            n_state = dra_pkg::B_TICK_RUN;
                        end
                        default: n_state = dra_pkg::B_IDLE;
                    endcase
                end
            end

            dra_pkg::B_ALLOC_RD: begin
                if (r_fd == '0) begin
                    n_state = dra_pkg::B_NOFREE;
                end else begin
                    // Entries below the low mark were never rewritten since rebuild
                    n_fd        = w_fd_dec;
                    n_pos       = w_top;
                    n_from_mark = (DW'(w_top) < r_low);
                    if (DW'(w_top) < r_low) begin
                        n_low = DW'(w_top);
                    end
                    n_state = dra_pkg::B_ALLOC_MUL;
                end
            end

            dra_pkg::B_ALLOC_MUL: begin
                n_idx   = w_pick;
                n_off   = dra_pkg::OFF_W'(w_pick) * dra_pkg::OFF_W'(i_cfg.stride);
                n_state = dra_pkg::B_ALLOC_ADD;
            end

            dra_pkg::B_ALLOC_ADD: begin
                o_res.granted_index = r_idx;
                o_res.cpu_address   = i_cfg.cpu_base + dra_pkg::ADDR_W'(r_off);
                o_res.gpu_address   = i_cfg.shader_visible ?
                                      i_cfg.gpu_base + dra_pkg::ADDR_W'(r_off) : '0;
                o_res.last          = (r_left == dra_pkg::COUNT_W'(1));
                o_res_push          = !i_res_full;
                if (!i_res_full) begin
                    if (r_left == dra_pkg::COUNT_W'(1)) begin
                        n_state = dra_pkg::B_IDLE;
                    end else begin
                        n_left  = r_left - 1'b1;
                        n_state = dra_pkg::B_ALLOC_RD;
                    end
                end
            end

            dra_pkg::B_NOFREE: begin
                o_res.status = dra_pkg::STATUS_NOFREE;
                o_res_push   = !i_res_full;
                if (!i_res_full) begin
                    n_state = dra_pkg::B_IDLE;
                end
            end

            dra_pkg::B_FREE: begin
                o_res_push = !i_res_full;
                if (r_pd >= FULL_DEPTH) begin
                    o_res.status = dra_pkg::STATUS_PFULL;
                end
                w_pnd_waddr          = r_pd[IW-1:0];
                w_pnd_wdata.slot     = r_slot;
                w_pnd_wdata.wait_cnt = (i_cfg.release_delay == '0) ?
                                       dra_pkg::WAIT_W'(1) : i_cfg.release_delay;
                if (!i_res_full) begin
                    if (r_pd < FULL_DEPTH) begin
                        w_pnd_we = 1'b1;
                        n_pd     = r_pd + DW'(1);
                    end
                    n_state = dra_pkg::B_IDLE;
                end
            end

            dra_pkg::B_TICK_RUN: begin
                // Issue one read per cycle, retire the entry read the cycle before
                if (r_rd < r_pd) begin
                    n_rd = r_rd + DW'(1);
                    n_tv = 1'b1;
                end else begin
                    n_tv = 1'b0;
                end
                if (r_tv) begin
                    if (w_wait_dec == '0) begin
                        if (r_fd < FULL_DEPTH) begin
                            w_stk_we = 1'b1;
                            n_fd     = r_fd + DW'(1);
                            n_rel    = r_rel + 1'b1;
                        end
                    end else begin
                        w_pnd_we             = 1'b1;
                        w_pnd_wdata.wait_cnt = w_wait_dec;
                        n_wr                 = r_wr + DW'(1);
                    end
                end
                if (!(r_rd < r_pd) && !r_tv) begin
                    n_pd    = r_wr;
                    n_state = dra_pkg::B_TICK_DONE;
                end
            end

            dra_pkg::B_TICK_DONE: begin
                o_res.released_count = r_rel;
                o_res_push           = !i_res_full;
                if (!i_res_full) begin
                    n_state = dra_pkg::B_IDLE;
                end
            end

            default: n_state = dra_pkg::B_IDLE;
        endcase

        // Capacity write: rebuild the stack as a pure low mark, drop the pending list
        if (i_rebuild.req) begin
            n_fd  = DW'(i_rebuild.capacity);
            n_low = DW'(i_rebuild.capacity);
            n_pd  = '0;
        end
    end

    assign o_stat.free_depth    = r_fd;
    assign o_stat.pending_depth = r_pd;

endmodule
`default_nettype wire

FILE: src/dra_outq.sv
`default_nettype none
module dra_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dra_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  empty,
    input  wire logic             pop,
    output dra_pkg::t_result      o_data
);

    dra_pkg::t_result                r_q [dra_pkg::OUTQ_DEPTH];
    logic [dra_pkg::OUTQ_PTR_W-1:0]  r_wp;
    logic [dra_pkg::OUTQ_PTR_W-1:0]  r_rp;
    logic [dra_pkg::OUTQ_CNT_W-1:0]  r_cnt;

    logic w_enq;
    logic w_deq;

    assign o_full = (r_cnt == dra_pkg::OUTQ_CNT_W'(dra_pkg::OUTQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_data = r_q[r_rp];
    assign w_enq  = i_push && !o_full;
    assign w_deq  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + dra_pkg::OUTQ_CNT_W'(w_enq) - dra_pkg::OUTQ_CNT_W'(w_deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: src/deferred_release_slot_allocator_core.sv
`default_nettype none
// Slot allocator with deferred release.
// Input channel (push/full): one item per accepted push. func selects allocate
// (count slots, clipped to the batch limit), free (queue slot_index for
// release_delay ticks) or frame tick (age the pending list, return expired slots).
// Result channel (empty/pop): results leave in order; an allocate gives one
// result per granted slot (a no-free-slot result if the stack runs dry), free
// and tick give one result each, and the final result of an item carries last.
// Config channel (i_cfg_valid/o_cfg_ready): always ready; write only while idle.
// The back engine takes a new command only while idle. An allocate takes the
// command, then per granted slot does a stack read, an offset multiply and a
// base add; a free queues one pending entry; a tick walks the pending list
// memory at one entry per cycle and then gives its result.
// Reset: the free stack reads as 0..capacity-1 at once through a low-water mark,
// so there is no clearing pass; the pending list is empty.
// Stall: a 4-entry result queue absorbs short stalls; the back engine holds
// when it fills, then the 2-entry command queue fills and full rises.
module deferred_release_slot_allocator_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    input  wire dra_pkg::t_item                   i_item,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output dra_pkg::t_result                      o_result,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [dra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dra_pkg::ADDR_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [dra_pkg::CAP_W-1:0]    r_capacity;
    logic                         r_shader;
    logic [dra_pkg::ADDR_W-1:0]   r_cpu_base;
    logic [dra_pkg::ADDR_W-1:0]   r_gpu_base;
    logic [dra_pkg::STRIDE_W-1:0] r_stride;
    logic [dra_pkg::WAIT_W-1:0]   r_delay;

    logic                       w_cfg_we;
    logic [dra_pkg::CAP_W-1:0]  w_cap_raw;
    logic [dra_pkg::CAP_W-1:0]  w_cap_sat;
    dra_pkg::t_cfg              w_cfg;
    dra_pkg::t_rebuild          w_rebuild;

    logic                       w_cmd_valid;
    logic                       w_cmd_ready;
    dra_pkg::t_cmd              w_cmd;
    logic                       w_res_push;
    logic                       w_outq_full;
    dra_pkg::t_result           w_res;
    dra_pkg::t_back_stat        w_stat;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_cap_raw   = i_cfg_data[dra_pkg::CAP_W-1:0];

    // Clamp capacity into 1..MAX_ENTRIES
    always_comb begin
        w_cap_sat = w_cap_raw;
        if (w_cap_raw == '0) begin
            w_cap_sat = dra_pkg::CAP_W'(1);
        end else if (int'(w_cap_raw) > dra_pkg::MAX_ENTRIES) begin
            w_cap_sat = dra_pkg::CAP_W'(dra_pkg::MAX_ENTRIES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= dra_pkg::CAP_W'(dra_pkg::CAP_RESET);
            r_shader   <= 1'b1;
            r_cpu_base <= '0;
            r_gpu_base <= '0;
            r_stride   <= dra_pkg::STRIDE_RESET;
            r_delay    <= dra_pkg::DELAY_RESET;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                dra_pkg::CFG_CAPACITY: r_capacity <= w_cap_sat;
                dra_pkg::CFG_SHADER:   r_shader   <= i_cfg_data[0];
                dra_pkg::CFG_CPU_BASE: r_cpu_base <= i_cfg_data;
                dra_pkg::CFG_GPU_BASE: r_gpu_base <= i_cfg_data;
                dra_pkg::CFG_STRIDE:   r_stride   <= i_cfg_data[dra_pkg::STRIDE_W-1:0];
                dra_pkg::CFG_DELAY:    r_delay    <= i_cfg_data[dra_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.shader_visible = r_shader;
    assign w_cfg.cpu_base       = r_cpu_base;
    assign w_cfg.gpu_base       = r_gpu_base;
    assign w_cfg.stride         = r_stride;
    assign w_cfg.release_delay  = r_delay;

    // A capacity write rebuilds the stack in the same edge it lands
    assign w_rebuild.req      = w_cfg_we && (i_cfg_index == dra_pkg::CFG_CAPACITY);
    assign w_rebuild.capacity = w_cap_sat;

    // Front: accept and classify items, buffer commands
    dra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // Back: run commands against the free stack and the pending list
    dra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_rebuild   (w_rebuild),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_outq_full),
        .o_stat      (w_stat)
    );

    // Result queue: hold finished results until the receiver pops them
    dra_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_outq_full),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_result)
    );

    // Never push a result into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_outq_full))
        else $error("result pushed into full queue");

    // Stack and pending depths stay within the memories
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(w_stat.free_depth) <= dra_pkg::MAX_ENTRIES) &&
        (int'(w_stat.pending_depth) <= dra_pkg::MAX_ENTRIES))
        else $error("stack or pending depth out of range");

    // A capacity write leaves a full stack of that size and no pending slots
    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rebuild.req |=>
        (w_stat.free_depth == dra_pkg::DEPTH_W'(r_capacity)) &&
        (w_stat.pending_depth == '0))
        else $error("rebuild did not restore stack");

    // A no-free-slot result ends its item and carries no grant
    a_nofree_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status == dra_pkg::STATUS_NOFREE)) |->
        (o_result.last && (o_result.granted_index == '0) &&
         (o_result.cpu_address == '0)))
        else $error("malformed no-free-slot result");

endmodule
`default_nettype wire
